// File: rtl/mfs_pkg.sv
// Shared types and constants of the periodic 1D field step block.
package mfs_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CoefW = 31;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned CfgIdxW = 2;
  // coefficient (31 bit) times difference (33 bit), plus headroom
  localparam int unsigned AccW  = 66;
  localparam int unsigned SumW  = 68;

  localparam logic [CfgIdxW-1:0] CfgHalfDtOverDx = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDtC2OverDx   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeStep     = 2'd2;

  typedef enum logic [1:0] {
    OP_WR_FIELD = 2'd0,
    OP_WR_CURR  = 2'd1,
    OP_ADVANCE  = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_BZ  = 3'd0,
    PH_BY  = 3'd1,
    PH_AVG = 3'd2,
    PH_EY  = 3'd3,
    PH_EZ  = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'd0,
    ST_IDLE  = 4'd1,
    ST_READ  = 4'd2,
    ST_RD    = 4'd3,
    ST_LD    = 4'd4,
    ST_MLO   = 4'd5,
    ST_MHI   = 4'd6,
    ST_RND   = 4'd7,
    ST_WR    = 4'd8
  } state_e;

  typedef struct packed {
    phase_e phase;
    logic   clr;
    logic   wr_f;
    logic   wr_c;
    logic   use_index;
    logic   rd;
    logic   ld;
    logic   mlo;
    logic   mhi;
    logic   rnd;
    logic   jpass;
    logic   wr_pt;
    logic   sat_clr;
    logic   out_ld_zero;
    logic   out_ld_read;
    logic   out_ld_adv;
    logic   rd_ok;
  } cmd_t;

endpackage

// File: rtl/mfs_ctrl.sv
// Controller: clearing pass, access handling and the advance sweep sequencer.
module mfs_ctrl #(
  parameter int unsigned GRID_POINTS = 256,
  localparam int unsigned AW = $clog2(GRID_POINTS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic [mfs_pkg::IdxW-1:0] index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output mfs_pkg::cmd_t            cmd_o,
  output logic [AW-1:0]            pt_o
);

  localparam logic [AW-1:0] LastPt = AW'(GRID_POINTS - 1);

  mfs_pkg::state_e state_q, state_d;
  mfs_pkg::phase_e phase_q, phase_d;
  logic [AW-1:0]   pt_q, pt_d;
  logic            jpass_q, jpass_d;
  logic            ok_q, ok_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free, accept, idx_ok, out_ld;
  mfs_pkg::op_e    op;

  assign op        = mfs_pkg::op_e'(operation_i);
  assign idx_ok    = {24'd0, index_i} < 32'(GRID_POINTS);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && (state_q == mfs_pkg::ST_IDLE) && slot_free;
  assign in_stall_o = !((state_q == mfs_pkg::ST_IDLE) && slot_free);
  assign out_ld    = cmd_o.out_ld_zero || cmd_o.out_ld_read || cmd_o.out_ld_adv;
  assign out_valid_d = (out_valid_q && out_stall_i) || out_ld;
  assign out_valid_o = out_valid_q;
  assign pt_o      = pt_q;

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    pt_d    = pt_q;
    jpass_d = jpass_q;
    ok_d    = ok_q;
    unique case (state_q)
      mfs_pkg::ST_CLEAR: begin
        if (pt_q == LastPt) begin
          pt_d    = '0;
          state_d = mfs_pkg::ST_IDLE;
        end else begin
          pt_d = pt_q + AW'(1);
        end
      end
      mfs_pkg::ST_IDLE: begin
        if (accept) begin
          if (op == mfs_pkg::OP_ADVANCE) begin
            state_d = mfs_pkg::ST_RD;
            phase_d = mfs_pkg::PH_BZ;
            pt_d    = '0;
            jpass_d = 1'b0;
          end else if (op == mfs_pkg::OP_READ) begin
            state_d = mfs_pkg::ST_READ;
            ok_d    = idx_ok;
          end
        end
      end
      mfs_pkg::ST_READ: state_d = mfs_pkg::ST_IDLE;
      mfs_pkg::ST_RD: begin
        state_d = (phase_q == mfs_pkg::PH_AVG) ? mfs_pkg::ST_WR : mfs_pkg::ST_LD;
      end
      mfs_pkg::ST_LD:  state_d = mfs_pkg::ST_MLO;
      mfs_pkg::ST_MLO: state_d = mfs_pkg::ST_MHI;
      mfs_pkg::ST_MHI: state_d = mfs_pkg::ST_RND;
      mfs_pkg::ST_RND: begin
        if ((phase_q == mfs_pkg::PH_EY || phase_q == mfs_pkg::PH_EZ) && !jpass_q) begin
          jpass_d = 1'b1;
          state_d = mfs_pkg::ST_LD;
        end else begin
          state_d = mfs_pkg::ST_WR;
        end
      end
      mfs_pkg::ST_WR: begin
        jpass_d = 1'b0;
        if (pt_q == LastPt) begin
          pt_d = '0;
          unique case (phase_q)
            mfs_pkg::PH_BZ:  phase_d = mfs_pkg::PH_BY;
            mfs_pkg::PH_BY:  phase_d = mfs_pkg::PH_AVG;
            mfs_pkg::PH_AVG: phase_d = mfs_pkg::PH_EY;
            mfs_pkg::PH_EY:  phase_d = mfs_pkg::PH_EZ;
            default:         phase_d = mfs_pkg::PH_BZ;
          endcase
          state_d = (phase_q == mfs_pkg::PH_EZ) ? mfs_pkg::ST_IDLE : mfs_pkg::ST_RD;
        end else begin
          pt_d    = pt_q + AW'(1);
          state_d = mfs_pkg::ST_RD;
        end
      end
      default: state_d = mfs_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    cmd_o.jpass = jpass_q;
    cmd_o.rd_ok = ok_q;
    unique case (state_q)
      mfs_pkg::ST_CLEAR: cmd_o.clr = 1'b1;
      mfs_pkg::ST_IDLE: begin
        cmd_o.use_index = 1'b1;
        if (accept) begin
          unique case (op)
            mfs_pkg::OP_WR_FIELD: begin
              cmd_o.wr_f        = idx_ok;
              cmd_o.out_ld_zero = 1'b1;
            end
            mfs_pkg::OP_WR_CURR: begin
              cmd_o.wr_c        = idx_ok;
              cmd_o.out_ld_zero = 1'b1;
            end
            mfs_pkg::OP_ADVANCE: cmd_o.sat_clr = 1'b1;
            default:             cmd_o.rd      = 1'b1;
          endcase
        end
      end
      mfs_pkg::ST_READ: cmd_o.out_ld_read = 1'b1;
      mfs_pkg::ST_RD:   cmd_o.rd  = 1'b1;
      mfs_pkg::ST_LD:   cmd_o.ld  = 1'b1;
      mfs_pkg::ST_MLO:  cmd_o.mlo = 1'b1;
      mfs_pkg::ST_MHI:  cmd_o.mhi = 1'b1;
      mfs_pkg::ST_RND:  cmd_o.rnd = 1'b1;
      mfs_pkg::ST_WR: begin
        cmd_o.wr_pt      = 1'b1;
        cmd_o.out_ld_adv = (pt_q == LastPt) && (phase_q == mfs_pkg::PH_EZ);
      end
      default: cmd_o.clr = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfs_pkg::ST_CLEAR;
      phase_q     <= mfs_pkg::PH_BZ;
      pt_q        <= '0;
      jpass_q     <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pt_q        <= pt_d;
      jpass_q     <= jpass_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a result is never loaded over one that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ld && out_valid_q) |-> !out_stall_i)
    else $error("result loaded over a held beat");

  // the current pass only exists in the E phases
  a_jpass_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jpass_q |-> (phase_q == mfs_pkg::PH_EY || phase_q == mfs_pkg::PH_EZ))
    else $error("current pass outside E update");

  // clearing pass ends in idle at point zero
  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfs_pkg::ST_CLEAR && pt_q == LastPt) |=>
    (state_q == mfs_pkg::ST_IDLE && pt_q == '0))
    else $error("clearing pass did not end cleanly");

endmodule

// File: rtl/mfs_dp.sv
// Datapath: field and current memories, shared multiplier, rounding and clipping.
module mfs_dp #(
  parameter int unsigned GRID_POINTS   = 256,
  parameter int unsigned FRACTION_BITS = 16,
  localparam int unsigned AW = $clog2(GRID_POINTS)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mfs_pkg::cmd_t                        cmd_i,
  input  logic [AW-1:0]                        pt_i,
  input  logic                                 cfg_we_i,
  input  logic [mfs_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [mfs_pkg::CoefW-1:0]            cfg_data_i,
  input  logic [mfs_pkg::IdxW-1:0]             index_i,
  input  logic signed [mfs_pkg::DataW-1:0]     by_in_i,
  input  logic signed [mfs_pkg::DataW-1:0]     bz_in_i,
  input  logic signed [mfs_pkg::DataW-1:0]     ey_in_i,
  input  logic signed [mfs_pkg::DataW-1:0]     ez_in_i,
  input  logic signed [mfs_pkg::DataW-1:0]     jy_in_i,
  input  logic signed [mfs_pkg::DataW-1:0]     jz_in_i,
  output logic signed [mfs_pkg::DataW-1:0]     by_out_o,
  output logic signed [mfs_pkg::DataW-1:0]     bz_out_o,
  output logic signed [mfs_pkg::DataW-1:0]     ey_out_o,
  output logic signed [mfs_pkg::DataW-1:0]     ez_out_o,
  output logic                                 saturated_o
);

  localparam int unsigned DW = mfs_pkg::DataW;
  localparam int unsigned AccW = mfs_pkg::AccW;
  localparam int unsigned SumW = mfs_pkg::SumW;
  localparam logic [AW-1:0] LastPt = AW'(GRID_POINTS - 1);
  localparam logic signed [AccW-1:0] RndHalf = AccW'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [SumW-1:0] SMax = SumW'(64'sh7FFF_FFFF);
  localparam logic signed [SumW-1:0] SMin = -SumW'(64'sh8000_0000);

  logic [mfs_pkg::CoefW-1:0] coef_h_q, coef_c_q, coef_t_q, coef;

  logic signed [DW-1:0] by_mem [GRID_POINTS];
  logic signed [DW-1:0] bz_mem [GRID_POINTS];
  logic signed [DW-1:0] ey_mem [GRID_POINTS];
  logic signed [DW-1:0] ez_mem [GRID_POINTS];
  logic signed [DW-1:0] jy_mem [GRID_POINTS];
  logic signed [DW-1:0] jz_mem [GRID_POINTS];

  logic signed [DW-1:0] by_a_q, bz_a_q, ey_a_q, ez_a_q, jy_a_q, jz_a_q;
  logic signed [DW-1:0] by_b_q, bz_b_q, ey_b_q, ez_b_q;

  logic [AW-1:0] addr_a, addr_b, waddr, nx, pv;
  logic          by_we, bz_we, ey_we, ez_we, jy_we, jz_we;
  logic signed [DW-1:0] by_wd, bz_wd, ey_wd, ez_wd, jy_wd, jz_wd;

  logic signed [DW:0]    m_op_q, diff, jval;
  logic signed [AccW-1:0] acc_q, rnd_sum, t1_q, t2_q;
  logic [46:0]           plo;
  logic signed [48:0]    phi;
  logic signed [SumW-1:0] base, sum;
  logic signed [DW:0]    avg_sum;
  logic signed [DW-1:0]  clip_val, res;
  logic                  clip_hit, sat_q, sat_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_h_q <= '0;
      coef_c_q <= '0;
      coef_t_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mfs_pkg::CfgHalfDtOverDx: coef_h_q <= cfg_data_i;
        mfs_pkg::CfgDtC2OverDx:   coef_c_q <= cfg_data_i;
        mfs_pkg::CfgTimeStep:     coef_t_q <= cfg_data_i;
        default:                  ;
      endcase
    end
  end

  // neighbor addresses with wraparound
  assign nx = (pt_i == LastPt) ? '0 : pt_i + AW'(1);
  assign pv = (pt_i == '0) ? LastPt : pt_i - AW'(1);
  assign addr_a = cmd_i.use_index ? AW'(index_i) : pt_i;
  assign addr_b = (cmd_i.phase == mfs_pkg::PH_BY || cmd_i.phase == mfs_pkg::PH_EY) ? pv : nx;
  assign waddr  = (cmd_i.wr_f || cmd_i.wr_c) ? AW'(index_i) : pt_i;

  // result of one sweep point
  always_comb begin
    base = '0;
    unique case (cmd_i.phase)
      mfs_pkg::PH_BZ: base = SumW'(bz_a_q);
      mfs_pkg::PH_BY: base = SumW'(by_a_q);
      mfs_pkg::PH_EY: base = SumW'(ey_a_q);
      default:        base = SumW'(ez_a_q);
    endcase
    unique case (cmd_i.phase)
      mfs_pkg::PH_BZ: sum = base - SumW'(t1_q);
      mfs_pkg::PH_BY: sum = base + SumW'(t1_q);
      mfs_pkg::PH_EY: sum = base - SumW'(t1_q) - SumW'(t2_q);
      default:        sum = base + SumW'(t1_q) - SumW'(t2_q);
    endcase
    clip_hit = 1'b0;
    if (sum > SMax) begin
      clip_val = SMax[DW-1:0];
      clip_hit = 1'b1;
    end else if (sum < SMin) begin
      clip_val = SMin[DW-1:0];
      clip_hit = 1'b1;
    end else begin
      clip_val = sum[DW-1:0];
    end
    avg_sum = ((DW+1)'(by_a_q) + (DW+1)'(by_b_q)) >>> 1;
    res = (cmd_i.phase == mfs_pkg::PH_AVG) ? avg_sum[DW-1:0] : clip_val;
  end

  assign sat_hit = cmd_i.wr_pt && (cmd_i.phase != mfs_pkg::PH_AVG) && clip_hit;

  always_comb begin
    by_we = cmd_i.clr || cmd_i.wr_f ||
            (cmd_i.wr_pt && (cmd_i.phase == mfs_pkg::PH_BY || cmd_i.phase == mfs_pkg::PH_AVG));
    bz_we = cmd_i.clr || cmd_i.wr_f || (cmd_i.wr_pt && cmd_i.phase == mfs_pkg::PH_BZ);
    ey_we = cmd_i.clr || cmd_i.wr_f || (cmd_i.wr_pt && cmd_i.phase == mfs_pkg::PH_EY);
    ez_we = cmd_i.clr || cmd_i.wr_f || (cmd_i.wr_pt && cmd_i.phase == mfs_pkg::PH_EZ);
    jy_we = cmd_i.clr || cmd_i.wr_c;
    jz_we = cmd_i.clr || cmd_i.wr_c;
    by_wd = cmd_i.clr ? '0 : (cmd_i.wr_f ? by_in_i : res);
    bz_wd = cmd_i.clr ? '0 : (cmd_i.wr_f ? bz_in_i : res);
    ey_wd = cmd_i.clr ? '0 : (cmd_i.wr_f ? ey_in_i : res);
    ez_wd = cmd_i.clr ? '0 : (cmd_i.wr_f ? ez_in_i : res);
    jy_wd = cmd_i.clr ? '0 : jy_in_i;
    jz_wd = cmd_i.clr ? '0 : jz_in_i;
  end

  always_ff @(posedge clk_i) begin
    if (by_we) by_mem[waddr] <= by_wd;
    if (cmd_i.rd) begin
      by_a_q <= by_mem[addr_a];
      by_b_q <= by_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bz_we) bz_mem[waddr] <= bz_wd;
    if (cmd_i.rd) begin
      bz_a_q <= bz_mem[addr_a];
      bz_b_q <= bz_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ey_we) ey_mem[waddr] <= ey_wd;
    if (cmd_i.rd) begin
      ey_a_q <= ey_mem[addr_a];
      ey_b_q <= ey_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ez_we) ez_mem[waddr] <= ez_wd;
    if (cmd_i.rd) begin
      ez_a_q <= ez_mem[addr_a];
      ez_b_q <= ez_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (jy_we) jy_mem[waddr] <= jy_wd;
    if (cmd_i.rd) jy_a_q <= jy_mem[addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (jz_we) jz_mem[waddr] <= jz_wd;
    if (cmd_i.rd) jz_a_q <= jz_mem[addr_a];
  end

  // multiplier operand: curl difference or current
  always_comb begin
    unique case (cmd_i.phase)
      mfs_pkg::PH_BZ: diff = (DW+1)'(ey_b_q) - (DW+1)'(ey_a_q);
      mfs_pkg::PH_BY: diff = (DW+1)'(ez_a_q) - (DW+1)'(ez_b_q);
      mfs_pkg::PH_EY: diff = (DW+1)'(bz_a_q) - (DW+1)'(bz_b_q);
      default:        diff = (DW+1)'(by_b_q) - (DW+1)'(by_a_q);
    endcase
    jval = (cmd_i.phase == mfs_pkg::PH_EY) ? (DW+1)'(jy_a_q) : (DW+1)'(jz_a_q);
    if (cmd_i.jpass) begin
      coef = coef_t_q;
    end else if (cmd_i.phase == mfs_pkg::PH_BZ || cmd_i.phase == mfs_pkg::PH_BY) begin
      coef = coef_h_q;
    end else begin
      coef = coef_c_q;
    end
  end

  // product split into a low 16-bit and a high 17-bit signed partial
  assign plo = coef * m_op_q[15:0];
  assign phi = $signed({1'b0, coef}) * $signed(m_op_q[DW:16]);
  assign rnd_sum = acc_q + RndHalf;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld)  m_op_q <= cmd_i.jpass ? jval : diff;
    if (cmd_i.mlo) acc_q  <= $signed(AccW'(plo));
    if (cmd_i.mhi) acc_q  <= acc_q + (AccW'(phi) <<< 16);
    if (cmd_i.rnd) begin
      if (cmd_i.jpass) t2_q <= rnd_sum >>> FRACTION_BITS;
      else             t1_q <= rnd_sum >>> FRACTION_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (cmd_i.sat_clr) begin
      sat_q <= 1'b0;
    end else if (sat_hit) begin
      sat_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld_zero || cmd_i.out_ld_adv) begin
      by_out_o    <= '0;
      bz_out_o    <= '0;
      ey_out_o    <= '0;
      ez_out_o    <= '0;
      saturated_o <= cmd_i.out_ld_adv && (sat_q || sat_hit);
    end else if (cmd_i.out_ld_read) begin
      by_out_o    <= cmd_i.rd_ok ? by_a_q : '0;
      bz_out_o    <= cmd_i.rd_ok ? bz_a_q : '0;
      ey_out_o    <= cmd_i.rd_ok ? ey_a_q : '0;
      ez_out_o    <= cmd_i.rd_ok ? ez_a_q : '0;
      saturated_o <= 1'b0;
    end
  end

endmodule

// File: rtl/periodic_1d_maxwell_field_step.sv
// Top level of the periodic 1D field step block.
// Input channel (in_valid_i / in_stall_o) takes one item per beat: an operation
// code, a grid index and write data. Output channel (out_valid_o / out_stall_i)
// gives exactly one result beat per item. Configuration is written through
// cfg_we_i / cfg_index_i / cfg_data_i; the user must write it only while the
// block is idle; the block does not enforce it. Write items: result registered
// at the accepting edge; next item can follow right away. Read items: registered
// memory read, then the output register. Advance items: every point is visited
// once per phase; a B update point reads, loads, multiplies low then high half
// on the shared split multiplier, rounds and writes; the By average reads and
// writes; an E update point multiplies twice, for curl and current. Intake is
// stalled during the sweep. After reset a clearing pass zeroes all six stores,
// with intake stalled. A held result is kept in the output register while the
// receiver stalls; a new item is taken only once that beat leaves.
module periodic_1d_maxwell_field_step #(
  parameter int unsigned GRID_POINTS   = 256,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mfs_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [mfs_pkg::CoefW-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           operation_i,
  input  logic [mfs_pkg::IdxW-1:0]             index_i,
  input  logic signed [mfs_pkg::DataW-1:0]     by_in_i,
  input  logic signed [mfs_pkg::DataW-1:0]     bz_in_i,
  input  logic signed [mfs_pkg::DataW-1:0]     ey_in_i,
  input  logic signed [mfs_pkg::DataW-1:0]     ez_in_i,
  input  logic signed [mfs_pkg::DataW-1:0]     jy_in_i,
  input  logic signed [mfs_pkg::DataW-1:0]     jz_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mfs_pkg::DataW-1:0]     by_out_o,
  output logic signed [mfs_pkg::DataW-1:0]     bz_out_o,
  output logic signed [mfs_pkg::DataW-1:0]     ey_out_o,
  output logic signed [mfs_pkg::DataW-1:0]     ez_out_o,
  output logic                                 saturated_o
);

  localparam int unsigned AW = $clog2(GRID_POINTS);

  mfs_pkg::cmd_t cmd;
  logic [AW-1:0] pt;

  mfs_ctrl #(
    .GRID_POINTS(GRID_POINTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .index_i    (index_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .pt_o       (pt)
  );

  mfs_dp #(
    .GRID_POINTS  (GRID_POINTS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .pt_i       (pt),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .index_i    (index_i),
    .by_in_i    (by_in_i),
    .bz_in_i    (bz_in_i),
    .ey_in_i    (ey_in_i),
    .ez_in_i    (ez_in_i),
    .jy_in_i    (jy_in_i),
    .jz_in_i    (jz_in_i),
    .by_out_o   (by_out_o),
    .bz_out_o   (bz_out_o),
    .ey_out_o   (ey_out_o),
    .ez_out_o   (ez_out_o),
    .saturated_o(saturated_o)
  );

endmodule
